[design/fqr_pkg.sv]
// Shared types and constants for the queue with reverse.
package fqr_pkg;

    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    // Action codes carried by an input transaction
    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_REV  = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    // Status codes carried by an output transaction
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming transaction
        logic exec;   // run the captured action against the ring
    } t_ctl_cmd;

endpackage

[design/fqr_in_if.sv]
// Input channel: action and value with valid/ready handshake.
interface fqr_in_if import fqr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

[design/fqr_out_if.sv]
// Output channel: status, dequeued value and count with valid/ready handshake.
interface fqr_out_if import fqr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  out_value;
    logic [COUNT_W-1:0]         count;

    modport source (output valid, output status, output out_value, output count,
                    input ready);
    modport sink   (input valid, input status, input out_value, input count,
                    output ready);
endinterface

[design/fqr_ctrl.sv]
// Controller state machine: sequences capture, execution and result handoff.
module fqr_ctrl import fqr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_ready,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_ctl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output handshakes open at once");

    a_load_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("captured transaction not executed next cycle");

    a_exec_then_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_out_valid)
        else $error("result not presented after execution");

    a_exec_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> !o_cmd.exec)
        else $error("one transaction executed twice");

endmodule

[design/fqr_dp.sv]
// Datapath: ring memory, head/count/direction registers and result registers.
module fqr_dp import fqr_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctl_cmd                  i_cmd,
    input  logic [ACTION_W-1:0]       i_action,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic [STATUS_W-1:0]       o_status,
    output logic signed [VALUE_W-1:0] o_out_value,
    output logic [COUNT_W-1:0]        o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    // Ring storage
    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    // Queue state
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic          r_rev;

    // Captured transaction and result
    logic [ACTION_W-1:0] r_action;
    logic [VALUE_W-1:0]  r_value;
    logic [STATUS_W-1:0] r_status;
    logic                r_deq_ok;

    logic          w_full;
    logic          w_empty;
    logic [SW-1:0] w_tail_sum;
    logic [SW-1:0] w_last_sum;
    logic [AW-1:0] w_tail_pos;
    logic [AW-1:0] w_last_pos;
    logic [AW-1:0] w_prev_head;
    logic [AW-1:0] w_next_head;
    logic [AW-1:0] w_wr_pos;
    logic [AW-1:0] w_rd_pos;
    logic          w_do_enq;
    logic          w_do_deq;
    logic          w_do_rev;
    logic [CW+COUNT_W-1:0] w_cnt_ext;

    // Ring positions, wrapped by one compare and subtract
    always_comb begin
        w_full      = (r_count == CW'(DEPTH));
        w_empty     = (r_count == '0);
        w_tail_sum  = SW'(r_head) + SW'(r_count);
        w_last_sum  = w_tail_sum - SW'(1);
        w_tail_pos  = (w_tail_sum >= SW'(DEPTH)) ? AW'(w_tail_sum - SW'(DEPTH))
                                                 : AW'(w_tail_sum);
        w_last_pos  = (w_last_sum >= SW'(DEPTH)) ? AW'(w_last_sum - SW'(DEPTH))
                                                 : AW'(w_last_sum);
        w_prev_head = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
        w_next_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
        // reversed: rear sits below head, front at the last entry
        w_wr_pos    = r_rev ? w_prev_head : w_tail_pos;
        w_rd_pos    = r_rev ? w_last_pos : r_head;
        w_do_enq    = i_cmd.exec && (r_action == ACT_ENQ) && !w_full;
        w_do_deq    = i_cmd.exec && (r_action == ACT_DEQ) && !w_empty;
        w_do_rev    = i_cmd.exec && (r_action == ACT_REV) && !w_empty;
    end

    // Capture the incoming transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
    end

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (w_do_enq) begin
            r_mem[w_wr_pos] <= r_value;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[w_rd_pos];
        end
    end

    // Head, count and direction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else begin
            if (w_do_enq) begin
                r_count <= r_count + CW'(1);
                if (r_rev) r_head <= w_prev_head;
            end
            if (w_do_deq) begin
                r_count <= r_count - CW'(1);
                if (!r_rev) r_head <= w_next_head;
            end
            if (w_do_rev) begin
                r_rev <= ~r_rev;
            end
        end
    end

    // Result status
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_deq_ok <= w_do_deq;
            priority if (r_action == ACT_ENQ && w_full) begin
                r_status <= ST_FULL;
            end else if ((r_action == ACT_DEQ || r_action == ACT_REV) && w_empty) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
        end
    end

    assign w_cnt_ext   = {{COUNT_W{1'b0}}, r_count};
    assign o_count     = w_cnt_ext[COUNT_W-1:0];
    assign o_status    = r_status;
    assign o_out_value = r_deq_ok ? r_rd_data : '0;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_no_enq_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_enq |=> r_count == $past(r_count) + CW'(1))
        else $error("enqueue did not grow the count");

    a_deq_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_deq |=> r_count == $past(r_count) - CW'(1))
        else $error("dequeue did not shrink the count");

endmodule

[design/fifo_queue_with_reverse.sv]
// Top level of the bounded queue of signed words with an order-reverse action.
//
// Usage:
//   i_in carries one transaction per operation: action (enqueue, dequeue,
//   reverse) and value (used by enqueue only). o_out returns exactly one
//   transaction per input: status (ok, full, empty), out_value (dequeued
//   word, else zero) and count (entries held afterward).
//   Reverse flips a direction flag, so it moves no entries.
//   Timing: the input is taken in the idle state, the ring is accessed in
//   the next cycle (one memory write or one registered read), and the result
//   is valid the cycle after that. Each item passes in order through the
//   capture, memory access and handoff states of the controller.
//   One operation is in flight at a time.
//   Reset (synchronous, active low) empties the queue and clears the
//   direction flag; ring contents are not cleared and need no clearing pass.
//   When the receiver stalls, the result holds on o_out and no new input
//   is taken until it is accepted.
module fifo_queue_with_reverse import fqr_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fqr_in_if.sink     i_in,
    fqr_out_if.source  o_out
);

    t_ctl_cmd w_cmd;

    // Sequencer
    fqr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    // Ring and queue state
    fqr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_action    (i_in.action),
        .i_value     (i_in.value),
        .o_status    (o_out.status),
        .o_out_value (o_out.out_value),
        .o_count     (o_out.count)
    );

endmodule
